[rtl/atrls_pkg.sv]
// Package with constants, register indexes and byte helpers for the AT response line scanner.
`default_nettype none

package atrls_pkg;

	localparam int BUF_DEPTH   = 1024;
	localparam int MAX_LINES   = 16;
	localparam int MAX_TAG_LEN = 8;
	localparam int TAG_COUNT   = 4;

	localparam int HIST_LEN    = 12;
	localparam int POS_W       = $clog2(BUF_DEPTH);
	localparam int LINE_W      = 4;
	localparam int LLEN_W      = 5;
	localparam int TLEN_W      = $clog2(MAX_TAG_LEN + 1);
	localparam int EOL_MAX     = 4;
	localparam int CFG_IDX_W   = 3;

	localparam logic [POS_W-1:0]  POS_LAST    = POS_W'(BUF_DEPTH - 1);
	localparam logic [LLEN_W-1:0] LLEN_MAX    = '1;
	localparam logic [LINE_W-1:0] LINE_CNT_MAX =
		(MAX_LINES - 1 > 15) ? LINE_W'(15) : LINE_W'(MAX_LINES - 1);

	localparam logic [31:0] EOL_CHARS_RST  = 32'd2573;
	localparam logic [2:0]  EOL_LENGTH_RST = 3'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELIM     = 3'd0,
		REG_EOL_CHARS = 3'd1,
		REG_EOL_LEN   = 3'd2,
		REG_TAG_ZERO  = 3'd3,
		REG_TAG_ONE   = 3'd4,
		REG_TAG_TWO   = 3'd5,
		REG_TAG_THREE = 3'd6
	} cfg_reg_t;

	typedef logic [7:0] byte_t;

	function automatic byte_t byte_of64(input logic [63:0] word, input logic [2:0] idx);
		return word[8*idx +: 8];
	endfunction

	function automatic byte_t byte_of32(input logic [31:0] word, input logic [1:0] idx);
		return word[8*idx +: 8];
	endfunction

	// Number of leading nonzero bytes, capped at the maximum tag length.
	function automatic logic [TLEN_W-1:0] tag_len(input logic [63:0] tag);
		logic [TLEN_W-1:0] n;
		logic              stop;
		n    = '0;
		stop = 1'b0;
		for (int k = 0; k < MAX_TAG_LEN; k++) begin
			if (!stop && tag[8*k +: 8] != 8'h00) begin
				n = n + TLEN_W'(1);
			end else begin
				stop = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

[rtl/at_response_line_scanner.sv]
// Top level of the AT response line scanner: delimiter flags, end-of-line and end-tag detection.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, cmd, byte_in          | into block
//  out     | out_valid, out_ready, byte_pos .. overflow| out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// One byte per cycle while the result is not stalled: a transfer is registered in an input
// stage, evaluated against the scan state and written to the result register. The input
// stage keeps taking transfers while the result register drains or is empty; a stalled
// result holds the input stage. Reset clears the scan state and loads the register
// defaults. The configuration port is always ready.
`default_nettype none

module at_response_line_scanner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           cmd,
	input  wire logic [7:0]                     byte_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [atrls_pkg::POS_W-1:0]         byte_pos,
	output logic                                is_delim,
	output logic                                eol_found,
	output logic [atrls_pkg::POS_W-1:0]         eol_start,
	output logic [atrls_pkg::LINE_W-1:0]        line_number,
	output logic                                tag_found,
	output logic [1:0]                          tag_index,
	output logic                                overflow,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [atrls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                    cfg_data
);
	import atrls_pkg::*;

	logic [63:0] delim_q;
	logic [31:0] eol_chars_q;
	logic [2:0]  eol_len_q;
	logic [63:0] tag_q [TAG_COUNT];

	logic [POS_W-1:0]  pos_q;
	byte_t             hist_q [HIST_LEN];
	logic [LLEN_W-1:0] llen_q;
	logic [LINE_W-1:0] lcnt_q;
	logic              ovf_q;

	logic  valid_s1;
	logic  cmd_s1;
	byte_t byte_s1;
	logic  advance;

	byte_t             hist_n [HIST_LEN];
	byte_t             win [MAX_TAG_LEN];
	logic [2:0]        len_c;
	logic              sat_c;
	logic [POS_W-1:0]  pos_n;
	logic [LLEN_W-1:0] llen_inc;
	logic              enough_c;
	logic [EOL_MAX-1:0] eol_by_len;
	logic              match_c;
	logic              short_c;
	logic [TAG_COUNT-1:0] tag_ok;
	logic [TLEN_W-1:0] tlen [TAG_COUNT];
	logic              delim_c;
	logic              delim_stop;
	logic              tag_hit_c;
	logic [1:0]        tag_idx_c;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_comb begin
		hist_n[0] = byte_s1;
		for (int k = 1; k < HIST_LEN; k++) begin
			hist_n[k] = hist_q[k-1];
		end

		if (eol_len_q == 3'd0) begin
			len_c = 3'd1;
		end else if (eol_len_q > 3'(EOL_MAX)) begin
			len_c = 3'(EOL_MAX);
		end else begin
			len_c = eol_len_q;
		end

		sat_c    = (pos_q >= POS_LAST);
		pos_n    = sat_c ? pos_q : pos_q + POS_W'(1);
		llen_inc = (llen_q < LLEN_MAX) ? llen_q + LLEN_W'(1) : llen_q;
		enough_c = ({1'b0, pos_q} + (POS_W+1)'(1)) >= (POS_W+1)'(len_c);

		for (int l = 1; l <= EOL_MAX; l++) begin
			eol_by_len[l-1] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (hist_n[k] != byte_of32(eol_chars_q, 2'(l - 1 - k))) begin
					eol_by_len[l-1] = 1'b0;
				end
			end
		end

		unique case (len_c)
			3'd1:    match_c = eol_by_len[0];
			3'd2:    match_c = eol_by_len[1];
			3'd3:    match_c = eol_by_len[2];
			default: match_c = eol_by_len[3];
		endcase
		match_c = match_c && enough_c;

		for (int k = 0; k < MAX_TAG_LEN; k++) begin
			unique case (len_c)
				3'd1:    win[k] = hist_n[1 + k];
				3'd2:    win[k] = hist_n[2 + k];
				3'd3:    win[k] = hist_n[3 + k];
				default: win[k] = hist_n[4 + k];
			endcase
		end

		// A line shorter than the end-of-line sequence leaves no bound on the tag length.
		short_c = (llen_inc < LLEN_W'(len_c));
		for (int j = 0; j < TAG_COUNT; j++) begin
			tlen[j]   = tag_len(tag_q[j]);
			tag_ok[j] = (tlen[j] != '0) &&
				(short_c || (LLEN_W'(tlen[j]) + LLEN_W'(len_c) <= llen_inc));
			for (int k = 0; k < MAX_TAG_LEN; k++) begin
				if (TLEN_W'(k) < tlen[j] &&
					win[k] != byte_of64(tag_q[j], 3'(tlen[j] - TLEN_W'(1) - TLEN_W'(k)))) begin
					tag_ok[j] = 1'b0;
				end
			end
		end

		tag_hit_c = 1'b0;
		tag_idx_c = 2'd0;
		for (int j = TAG_COUNT - 1; j >= 0; j--) begin
			if (tag_ok[j]) begin
				tag_hit_c = 1'b1;
				tag_idx_c = 2'(j);
			end
		end

		delim_c    = 1'b0;
		delim_stop = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (delim_q[8*k +: 8] == 8'h00) begin
				delim_stop = 1'b1;
			end else if (!delim_stop && delim_q[8*k +: 8] == byte_s1) begin
				delim_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q     <= '0;
			eol_chars_q <= EOL_CHARS_RST;
			eol_len_q   <= EOL_LENGTH_RST;
			for (int j = 0; j < TAG_COUNT; j++) begin
				tag_q[j] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELIM:     delim_q     <= cfg_data;
				REG_EOL_CHARS: eol_chars_q <= cfg_data[31:0];
				REG_EOL_LEN:   eol_len_q   <= cfg_data[2:0];
				REG_TAG_ZERO:  tag_q[0]    <= cfg_data;
				REG_TAG_ONE:   tag_q[1]    <= cfg_data;
				REG_TAG_TWO:   tag_q[2]    <= cfg_data;
				REG_TAG_THREE: tag_q[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			llen_q <= '0;
			lcnt_q <= '0;
			ovf_q  <= 1'b0;
			for (int k = 0; k < HIST_LEN; k++) begin
				hist_q[k] <= '0;
			end
		end else if (advance) begin
			if (cmd_s1) begin
				pos_q  <= '0;
				llen_q <= '0;
				lcnt_q <= '0;
				ovf_q  <= 1'b0;
				for (int k = 0; k < HIST_LEN; k++) begin
					hist_q[k] <= '0;
				end
			end else begin
				pos_q <= pos_n;
				if (sat_c) begin
					ovf_q <= 1'b1;
				end
				for (int k = 0; k < HIST_LEN; k++) begin
					hist_q[k] <= hist_n[k];
				end
				if (match_c) begin
					llen_q <= '0;
					if (lcnt_q < LINE_CNT_MAX) begin
						lcnt_q <= lcnt_q + LINE_W'(1);
					end
				end else begin
					llen_q <= llen_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd_s1) begin
				byte_pos    <= '0;
				is_delim    <= 1'b0;
				eol_found   <= 1'b0;
				eol_start   <= '0;
				line_number <= '0;
				tag_found   <= 1'b0;
				tag_index   <= '0;
				overflow    <= 1'b0;
			end else begin
				byte_pos    <= pos_q;
				is_delim    <= delim_c;
				eol_found   <= match_c;
				eol_start   <= match_c ? pos_q - POS_W'(len_c - 3'd1) : '0;
				line_number <= match_c ? lcnt_q : '0;
				tag_found   <= match_c && tag_hit_c;
				tag_index   <= (match_c && tag_hit_c) ? tag_idx_c : 2'd0;
				overflow    <= ovf_q || sat_c;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("Input stalled without a held result.");

	a_tag_needs_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tag_found) |-> eol_found)
		else $error("Tag reported without an end of line.");

	a_no_eol_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !eol_found) |->
			(eol_start == '0 && line_number == '0 && tag_index == 2'd0))
		else $error("Line fields set without an end of line.");

	a_eol_start_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && eol_found) |-> (eol_start <= byte_pos))
		else $error("End-of-line start lies after the byte position.");

	a_overflow_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (byte_pos == POS_LAST))
		else $error("Overflow reported below the last position.");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the AT response line scanner with a scoreboard class and random traffic.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atrls_pkg::*;

	localparam byte_t CR = 8'h0D;
	localparam byte_t LF = 8'h0A;

	typedef struct packed {
		logic [POS_W-1:0]  byte_pos;
		logic              is_delim;
		logic              eol_found;
		logic [POS_W-1:0]  eol_start;
		logic [LINE_W-1:0] line_number;
		logic              tag_found;
		logic [1:0]        tag_index;
		logic              overflow;
	} scan_result_t;

	class line_scoreboard;
		logic [63:0]       delims;
		logic [31:0]       eol_bytes;
		logic [2:0]        eol_len_reg;
		logic [63:0]       tag_words [4];
		logic [POS_W-1:0]  next_pos;
		byte_t             history [HIST_LEN];
		logic [LLEN_W-1:0] line_len;
		logic [LINE_W-1:0] lines_done;
		logic              ovf_seen;
		scan_result_t      expected_q [$];
		int                errors;
		int                results_seen;

		function new();
			delims = '0;
			eol_bytes = EOL_CHARS_RST;
			eol_len_reg = EOL_LENGTH_RST;
			foreach (tag_words[j]) tag_words[j] = '0;
			errors = 0;
			results_seen = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			next_pos = '0;
			foreach (history[k]) history[k] = '0;
			line_len = '0;
			lines_done = '0;
			ovf_seen = 1'b0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [63:0] data);
			case (idx)
			REG_DELIM:     delims = data;
			REG_EOL_CHARS: eol_bytes = data[31:0];
			REG_EOL_LEN:   eol_len_reg = data[2:0];
			REG_TAG_ZERO:  tag_words[0] = data;
			REG_TAG_ONE:   tag_words[1] = data;
			REG_TAG_TWO:   tag_words[2] = data;
			REG_TAG_THREE: tag_words[3] = data;
			default: ;
			endcase
		endfunction

		function int unsigned eol_size();
			if (eol_len_reg < 1) return 1;
			if (eol_len_reg > EOL_MAX) return EOL_MAX;
			return eol_len_reg;
		endfunction

		function int unsigned tag_size(int j);
			int unsigned n;
			n = 0;
			while (n < MAX_TAG_LEN && n < 8 && tag_words[j][8*n +: 8] != 8'h00) n++;
			return n;
		endfunction

		function bit delim_match(byte_t b);
			for (int k = 0; k < 8; k++) begin
				if (delims[8*k +: 8] == 8'h00) return 1'b0;
				if (delims[8*k +: 8] == b) return 1'b1;
			end
			return 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_input(logic clear, byte_t b);
			scan_result_t r;
			int unsigned  pos, len, text_len, x;
			bit           hit, ok;
			r = '0;
			if (clear) begin
				clear_scan();
				expected_q.push_back(r);
				return;
			end
			pos = next_pos;
			if (pos >= BUF_DEPTH - 1) begin
				pos = BUF_DEPTH - 1;
				ovf_seen = 1'b1;
			end else begin
				next_pos = POS_W'(pos + 1);
			end
			for (int k = HIST_LEN - 1; k > 0; k--) history[k] = history[k-1];
			history[0] = b;
			if (line_len < LLEN_MAX) line_len++;
			len = eol_size();
			hit = (pos + 1 >= len);
			for (int k = 0; k < len; k++) begin
				if (history[k] != eol_bytes[8*(len-1-k) +: 8]) hit = 1'b0;
			end
			if (hit) begin
				text_len = line_len - len;
				r.eol_found = 1'b1;
				r.eol_start = POS_W'(pos + 1 - len);
				r.line_number = lines_done;
				if (lines_done < LINE_CNT_MAX) lines_done++;
				for (int j = 0; j < TAG_COUNT && !r.tag_found; j++) begin
					x = tag_size(j);
					ok = (x > 0 && x <= text_len);
					for (int k = 0; k < x && ok; k++) begin
						if (history[len+k] != tag_words[j][8*(x-1-k) +: 8]) ok = 1'b0;
					end
					if (ok) begin
						r.tag_found = 1'b1;
						r.tag_index = 2'(j);
					end
				end
				line_len = '0;
			end
			r.byte_pos = POS_W'(pos);
			r.is_delim = delim_match(b);
			r.overflow = ovf_seen;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 50) $display("%0t tb: mismatch: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want) begin
				report($sformatf("result %0d %s is %0d, expected %0d",
					results_seen, name, got, want));
			end
		endtask

		task check(scan_result_t got);
			scan_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with no transfer outstanding", results_seen));
				return;
			end
			want = expected_q.pop_front();
			compare_field("byte_pos", 16'(got.byte_pos), 16'(want.byte_pos));
			compare_field("is_delim", 16'(got.is_delim), 16'(want.is_delim));
			compare_field("eol_found", 16'(got.eol_found), 16'(want.eol_found));
			compare_field("eol_start", 16'(got.eol_start), 16'(want.eol_start));
			compare_field("line_number", 16'(got.line_number), 16'(want.line_number));
			compare_field("tag_found", 16'(got.tag_found), 16'(want.tag_found));
			compare_field("tag_index", 16'(got.tag_index), 16'(want.tag_index));
			compare_field("overflow", 16'(got.overflow), 16'(want.overflow));
		endtask

		task flush_leftovers();
			while (expected_q.size() != 0) begin
				void'(expected_q.pop_front());
				report("expected result never arrived");
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  cmd = 1'b0;
	logic [7:0]            byte_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [POS_W-1:0]      byte_pos;
	logic                  is_delim;
	logic                  eol_found;
	logic [POS_W-1:0]      eol_start;
	logic [LINE_W-1:0]     line_number;
	logic                  tag_found;
	logic [1:0]            tag_index;
	logic                  overflow;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [63:0]           cfg_data = '0;

	line_scoreboard sb = new();
	logic [63:0]    cfg_val [REG_TAG_THREE + 1];
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             hold_cycles = 0;
	int             items_sent = 0;

	at_response_line_scanner u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				sb.check({byte_pos, is_delim, eol_found, eol_start, line_number,
					tag_found, tag_index, overflow});
			end
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(input logic clear, input byte_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= clear;
		byte_in <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(clear, b);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++) send_item(1'b0, byte_t'(s[k]));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config();
		for (int i = REG_DELIM; i <= REG_TAG_THREE; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= cfg_val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.write_reg(cfg_reg_t'(i), cfg_val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic byte_t rand_char();
		if ($urandom_range(0, 9) < 7) return byte_t'(8'h41 + $urandom_range(0, 3));
		return byte_t'($urandom_range(1, 255));
	endfunction

	function automatic byte_t rand_eol_byte();
		case ($urandom_range(0, 4))
		0: return CR;
		1: return LF;
		2: return 8'h00;
		default: return rand_char();
		endcase
	endfunction

	function automatic logic [63:0] rand_tag();
		logic [63:0] t;
		int          n;
		t = '0;
		case ($urandom_range(0, 5))
		0: t = '0;
		1: t = {$urandom, $urandom};
		2: t = '1;
		default: begin
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++) t[8*k +: 8] = rand_char();
		end
		endcase
		return t;
	endfunction

	function automatic void randomize_config();
		int n;
		case ($urandom_range(0, 4))
		0: cfg_val[REG_DELIM] = '0;
		1: cfg_val[REG_DELIM] = {$urandom, $urandom};
		default: begin
			cfg_val[REG_DELIM] = '0;
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++) cfg_val[REG_DELIM][8*k +: 8] = rand_char();
		end
		endcase
		cfg_val[REG_EOL_CHARS] = {$urandom, $urandom};
		for (int k = 0; k < 4; k++) cfg_val[REG_EOL_CHARS][8*k +: 8] = rand_eol_byte();
		cfg_val[REG_EOL_LEN] = {$urandom, $urandom};
		cfg_val[REG_EOL_LEN][2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		for (int j = 0; j < 4; j++) cfg_val[REG_TAG_ZERO + j] = rand_tag();
	endfunction

	function automatic byte_t pool_byte();
		case ($urandom_range(0, 3))
		0: return byte_t'($urandom_range(0, 255));
		1: return cfg_val[REG_EOL_CHARS][8*$urandom_range(0, 3) +: 8];
		2: return cfg_val[REG_DELIM][8*$urandom_range(0, 7) +: 8];
		default: return cfg_val[REG_TAG_ZERO + $urandom_range(0, 3)][8*$urandom_range(0, 7) +: 8];
		endcase
	endfunction

	// Mostly well-formed lines (text, an end tag, the end-of-line bytes), plus noise,
	// broken end-of-line sequences, long lines and the occasional clear.
	task automatic emit_line(input bit allow_clear);
		int unsigned r, n, j, len;
		r = $urandom_range(0, 99);
		len = sb.eol_size();
		if (allow_clear && r < 5) begin
			send_item(1'b1, byte_t'($urandom_range(0, 255)));
		end else if (r < 20) begin
			repeat ($urandom_range(1, 6)) send_item(1'b0, byte_t'($urandom_range(0, 255)));
		end else begin
			n = (r < 24) ? $urandom_range(24, 40) : $urandom_range(0, 5);
			repeat (n) send_item(1'b0, pool_byte());
			if ($urandom_range(0, 2) != 0) begin
				j = $urandom_range(0, 3);
				n = sb.tag_size(j);
				for (int k = 0; k < n; k++) send_item(1'b0, cfg_val[REG_TAG_ZERO + j][8*k +: 8]);
			end
			n = (r < 30) ? $urandom_range(0, len - 1) : len;
			for (int k = 0; k < n; k++) send_item(1'b0, cfg_val[REG_EOL_CHARS][8*k +: 8]);
		end
	endtask

	task automatic run_phase(input int n, input bit allow_clear);
		int target;
		target = items_sent + n;
		while (items_sent < target) emit_line(allow_clear);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_val[REG_DELIM]     = 64'h2B00_0A0D_FF20_3A2C;
		cfg_val[REG_EOL_CHARS] = 64'h0000_0A0D;
		cfg_val[REG_EOL_LEN]   = 64'd2;
		cfg_val[REG_TAG_ZERO]  = 64'h52_4F52_5245;
		cfg_val[REG_TAG_ONE]   = 64'h4B4F;
		cfg_val[REG_TAG_TWO]   = 64'h4B0A;
		cfg_val[REG_TAG_THREE] = '1;
		apply_config();
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_text("OK");
		send_item(1'b0, CR);
		send_item(1'b0, LF);
		send_text("K");
		send_item(1'b0, CR);
		send_item(1'b0, LF);
		send_text("ERROR");
		send_item(1'b0, CR);
		send_item(1'b0, LF);
		send_text("+");
		send_item(1'b1, 8'hFF);
		send_item(1'b0, LF);
		drain();

		// Four-byte end of line holding zero bytes, right after a clear.
		cfg_val[REG_DELIM]     = '0;
		cfg_val[REG_EOL_CHARS] = 64'h0A0D_0000;
		cfg_val[REG_EOL_LEN]   = 64'd7;
		cfg_val[REG_TAG_ZERO]  = 64'h0A0D;
		cfg_val[REG_TAG_ONE]   = '0;
		cfg_val[REG_TAG_TWO]   = '0;
		cfg_val[REG_TAG_THREE] = '0;
		apply_config();
		send_item(1'b1, 8'h00);
		send_item(1'b0, CR);
		send_item(1'b0, LF);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b0, CR);
		send_item(1'b0, LF);
		drain();

		// No clear from here on, so the position saturates during the last phase.
		randomize_config();
		apply_config();
		set_idling(0, 0);
		run_phase(250, 1'b0);
		drain();

		randomize_config();
		apply_config();
		set_idling(75, 0);
		run_phase(250, 1'b0);
		drain();

		foreach (cfg_val[i]) cfg_val[i] = '0;
		apply_config();
		set_idling(0, 75);
		hold_cycles = 300;
		run_phase(250, 1'b0);
		drain();

		foreach (cfg_val[i]) cfg_val[i] = '1;
		apply_config();
		set_idling(29, 29);
		run_phase(275, 1'b0);
		drain();

		sb.flush_leftovers();
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
